// File: src/f2p_pkg.sv
// Shared types and constants for the float32 to PCM16 converter.
package f2p_pkg;

  localparam int unsigned FloatW = 32;
  localparam int unsigned PcmW   = 16;
  localparam int unsigned ProdW  = 39;

  localparam logic [14:0] PcmGain = 15'd32767;
  localparam logic [16:0] MagMax  = 17'd32767;
  localparam logic [16:0] MagMin  = 17'd32768;
  localparam logic signed [PcmW-1:0] PcmMax = 16'sh7fff;
  localparam logic signed [PcmW-1:0] PcmMin = 16'sh8000;

  localparam logic [7:0] ExpSpecial = 8'hff;
  localparam logic [7:0] ExpDenorm  = 8'h00;

  typedef struct packed {
    logic             sign;
    logic             nan;
    logic             inf;
    logic             denorm;
    logic [7:0]       expo;
    logic [ProdW-1:0] prod;
    logic             last;
  } prod_t;

endpackage

// File: src/f2p_if.sv
// Stream interfaces for float input beats and PCM output beats.
interface f2p_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;
  logic        last_in;
  modport source (output valid, output float_bits, output last_in, input ready);
  modport sink   (input valid, input float_bits, input last_in, output ready);
endinterface

interface f2p_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               last_out;
  modport source (output valid, output pcm_sample, output last_out, input ready);
  modport sink   (input valid, input pcm_sample, input last_out, output ready);
endinterface

// File: src/f2p_mul.sv
// Unpack the float and form the exact mantissa times gain product.
module f2p_mul (
  input  logic                   clk_i,
  input  logic [31:0]            float_bits_i,
  input  logic                   last_i,
  output f2p_pkg::prod_t         prod_o
);
  import f2p_pkg::*;

  logic [7:0]  expo;
  logic [22:0] frac;
  logic [23:0] mant;

  assign expo = float_bits_i[30:23];
  assign frac = float_bits_i[22:0];
  assign mant = {1'b1, frac};

  always_comb begin
    prod_o.sign   = float_bits_i[31];
    prod_o.nan    = (expo == ExpSpecial) && (frac != '0);
    prod_o.inf    = (expo == ExpSpecial) && (frac == '0);
    prod_o.denorm = (expo == ExpDenorm);
    prod_o.expo   = expo;
    prod_o.prod   = ProdW'(mant) * ProdW'(PcmGain);
    prod_o.last   = last_i;
  end
endmodule

// File: src/f2p_round.sv
// Round product to single precision, then saturate and round to integer.
module f2p_round (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  f2p_pkg::prod_t              prod_i,
  output logic signed [15:0]          pcm_o,
  output logic                        last_o
);
  import f2p_pkg::*;

  logic               top;
  logic [23:0]        keep;
  logic               half;
  logic               sticky;
  logic               up;
  logic [24:0]        rnd;
  logic signed [9:0]  sh;
  logic               sat;
  logic               zero;
  logic [4:0]         sh_m1;
  logic [24:0]        rs;
  logic [16:0]        mag;
  logic signed [15:0] pcm_d, pcm_q;
  logic               last_q;

  always_comb begin
    top    = prod_i.prod[38];
    keep   = top ? prod_i.prod[38:15] : prod_i.prod[37:14];
    half   = top ? prod_i.prod[14] : prod_i.prod[13];
    sticky = top ? (|prod_i.prod[13:0]) : (|prod_i.prod[12:0]);
    up     = half && (sticky || keep[0]);
    rnd    = {1'b0, keep} + 25'(up);
    sh     = $signed({2'b00, (top ? 8'd135 : 8'd136)}) - $signed({2'b00, prod_i.expo});
    sat    = prod_i.inf || (sh < 10'sd9);
    zero   = prod_i.nan || prod_i.denorm || (sh > 10'sd25);
    sh_m1  = sh[4:0] - 5'd1;
    rs     = rnd >> sh_m1;
    mag    = {1'b0, rs[16:1]} + 17'(rs[0]);
    if (zero) begin
      pcm_d = '0;
    end else if (!prod_i.sign) begin
      pcm_d = (sat || (mag > MagMax)) ? PcmMax : $signed(mag[15:0]);
    end else begin
      pcm_d = (sat || (mag > MagMin)) ? PcmMin : $signed(16'(-mag));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pcm_q  <= pcm_d;
      last_q <= prod_i.last;
    end
  end

  assign pcm_o  = pcm_q;
  assign last_o = last_q;
endmodule

// File: src/float32_to_pcm16_converter.sv
// Float32 to PCM16 converter top level.
// Converts one IEEE-754 single sample per beat to a saturated signed 16-bit PCM
// sample (x * 32767, rounded to single, then rounded half away from zero; NaN
// gives 0). Throughput is one beat per cycle unless the output stalls; each beat
// passes an input register and the output register, with the 24x15 product and
// all rounding in between. The whole pipeline holds while the output beat is not taken.
module float32_to_pcm16_converter (
  input  logic  clk_i,
  input  logic  rst_ni,
  f2p_in_if.sink    in_i,
  f2p_out_if.source out_o
);
  import f2p_pkg::*;

  logic        en;
  logic [1:0]  vld_q;
  logic [31:0] bits_q;
  logic        last_q;
  prod_t       prod;

  assign en         = !(vld_q[1] && !out_o.ready);
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bits_q <= in_i.float_bits;
      last_q <= in_i.last_in;
    end
  end

  f2p_mul u_mul (
    .clk_i        (clk_i),
    .float_bits_i (bits_q),
    .last_i       (last_q),
    .prod_o       (prod)
  );

  f2p_round u_round (
    .clk_i  (clk_i),
    .en_i   (en),
    .prod_i (prod),
    .pcm_o  (out_o.pcm_sample),
    .last_o (out_o.last_out)
  );

  assign out_o.valid = vld_q[1];
endmodule

// File: src/f2p_checker.sv
// Port-level checks for the converter, bound to the top level.
module f2p_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_pcm
);
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pcm))
    else $error("stalled output beat changed");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd2)
    else $error("more beats in flight than pipeline stages");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 3'd0 |-> !out_valid)
    else $error("output beat without matching input beat");
endmodule

bind float32_to_pcm16_converter f2p_checker u_f2p_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_pcm   (out_o.pcm_sample)
);

// File: dv/testbench.sv
// Self-checking testbench for the float32 to PCM16 converter.
`timescale 1ns / 100ps

module testbench;
  import f2p_pkg::*;

  localparam int NumRandom  = 1200;
  localparam int QuietTail  = 200;
  localparam int StallLimit = 1000;

  // Bit-exact conversion: 24x15 product, round to single (RNE), saturate,
  // then round half away from zero.
  function automatic logic signed [PcmW-1:0] float_to_pcm(logic [FloatW-1:0] f);
    logic             s;
    int               e;
    logic [ProdW-1:0] prod;
    logic [ProdW-1:0] r;
    logic [ProdW-1:0] rem;
    logic [ProdW-1:0] half;
    int               drop;
    int               k;
    int               n;
    logic [63:0]      q;
    s = f[31];
    e = int'(f[30:23]);
    if (f[30:23] == ExpSpecial) begin
      if (f[22:0] != 0) return '0;
      return s ? PcmMin : PcmMax;
    end
    if (f[30:23] == ExpDenorm) return '0;
    prod = ProdW'({1'b1, f[22:0]}) * ProdW'(PcmGain);
    drop = prod[ProdW-1] ? 15 : 14;
    r    = prod >> drop;
    rem  = prod & ((ProdW'(1) << drop) - 1);
    half = ProdW'(1) << (drop - 1);
    if (rem > half || (rem == half && r[0])) r = r + 1;
    k = drop + e - 150;
    if (k >= 0) begin
      q = 64'd40000;
    end else begin
      n = -k;
      q = (n > 40) ? 64'd0 : ((64'(r) + (64'd1 << (n - 1))) >> n);
    end
    if (!s) return (q > 64'd32767) ? PcmMax : PcmW'(q);
    return (q >= 64'd32768) ? PcmMin : -PcmW'(q);
  endfunction

  class pcm_scoreboard;
    logic signed [PcmW-1:0] pcm_q[$];
    logic                   last_q[$];
    int                     errors;

    function new();
      errors = 0;
    endfunction

    function void note(logic [FloatW-1:0] bits, logic last);
      pcm_q.push_back(float_to_pcm(bits));
      last_q.push_back(last);
    endfunction

    function void check(logic signed [PcmW-1:0] pcm, logic last);
      logic signed [PcmW-1:0] exp_pcm;
      logic                   exp_last;
      if (pcm_q.size() == 0) begin
        $display("%0t: unexpected beat pcm=%0d last=%0b", $time, pcm, last);
        errors++;
        return;
      end
      exp_pcm  = pcm_q.pop_front();
      exp_last = last_q.pop_front();
      if (pcm !== exp_pcm) begin
        $display("%0t: pcm mismatch expected %0d actual %0d", $time, exp_pcm, pcm);
        errors++;
      end
      if (last !== exp_last) begin
        $display("%0t: last mismatch expected %0b actual %0b", $time, exp_last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pcm_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic quiet;
  int   idle_cycles;
  int   stall_left;
  pcm_scoreboard sb;

  f2p_in_if  in_if();
  f2p_out_if out_if();

  float32_to_pcm16_converter dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
      idle_cycles  <= 0;
    end else begin
      if (out_if.valid && out_if.ready) sb.check(out_if.pcm_sample, out_if.last_out);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        stall_left   <= $urandom_range(0, 4);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(logic [FloatW-1:0] bits, logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.float_bits <= bits;
    in_if.last_in    <= last;
    do @(posedge clk); while (!in_if.ready);
    sb.note(bits, last);
  endtask

  function automatic logic [FloatW-1:0] random_sample();
    logic [FloatW-1:0] f;
    f = $urandom();
    case ($urandom_range(0, 9))
      0, 1:    ;
      2:       f[30:23] = ExpSpecial;
      3:       f[30:23] = ExpDenorm;
      4:       f[30:23] = 8'($urandom_range(127, 150));
      default: f[30:23] = 8'($urandom_range(100, 126));
    endcase
    return f;
  endfunction

  logic [FloatW-1:0] directed[$] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000,
    32'h3f00_0000, 32'hbf00_0000, 32'h7f80_0000, 32'hff80_0000,
    32'h7fc0_0000, 32'hffc0_0001, 32'h7f80_0001, 32'h0000_0001,
    32'h807f_ffff, 32'h7f7f_ffff, 32'hff7f_ffff, 32'h4000_0000,
    32'hc000_0000, 32'h3f80_0001, 32'hbf80_0001, 32'h3800_0100,
    32'hb800_0100, 32'h3f7f_ffff, 32'hffff_ffff
  };

  initial begin
    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.float_bits <= '0;
    in_if.last_in    <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_sample(directed[i], i[0]);
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) begin
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if (i == NumRandom - QuietTail) quiet = 1'b1;
      send_sample(random_sample(), 1'($urandom()));
    end
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
